>>> rtl/mmps_pkg.sv
// Shared types and constants for the multimap pair store.
// Used by mmps_cell and multimap_pair_store; depends on nothing else.
package mmps_pkg;

  // store geometry
  localparam int PairCapacity = 64;
  localparam int IdxW         = (PairCapacity > 1) ? $clog2(PairCapacity) : 1;
  localparam int CntW         = 7;
  localparam int DataW        = 32;

  // stream payload widths
  localparam int InTdataW  = 72;
  localparam int OutTdataW = 48;

  // command codes
  localparam logic [1:0] CmdAdd    = 2'd0;
  localparam logic [1:0] CmdRemove = 2'd1;
  localparam logic [1:0] CmdSearch = 2'd2;

  // status codes
  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatNotFound = 2'd1;
  localparam logic [1:0] StatFull     = 2'd2;

  // sequencer states
  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish,
    StResult
  } state_e;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic            shift;
    logic            compact;
    logic [IdxW-1:0] drop_idx;
  } cell_ctrl_t;

endpackage

>>> rtl/mmps_cell.sv
// One slot of the pair chain: holds a key and a value and loads from its
// neighbor on a rotate step or a compaction step. Depends on mmps_pkg.
module mmps_cell (
  input  logic                        clk_i,
  input  mmps_pkg::cell_ctrl_t        ctrl_i,
  input  logic [mmps_pkg::IdxW-1:0]   idx_i,
  input  logic [mmps_pkg::DataW-1:0]  key_i,
  input  logic [mmps_pkg::DataW-1:0]  value_i,
  output logic [mmps_pkg::DataW-1:0]  key_o,
  output logic [mmps_pkg::DataW-1:0]  value_o
);
  import mmps_pkg::*;

  logic [DataW-1:0] key_q;
  logic [DataW-1:0] value_q;
  logic             load;

  // rotate moves every cell, compaction only cells at or behind the removed slot
  assign load = ctrl_i.shift | (ctrl_i.compact & (idx_i >= ctrl_i.drop_idx));

  // slot storage
  always_ff @(posedge clk_i) begin
    if (load) begin
      key_q   <= key_i;
      value_q <= value_i;
    end
  end

  assign key_o   = key_q;
  assign value_o = value_q;

endmodule

>>> rtl/multimap_pair_store.sv
// Multimap pair store: a chain of key/value slots scanned by rotation.
// Depends on mmps_pkg and mmps_cell.
//
// Requests enter on the s_axis channel (cmd, key, value), one at a time:
// s_axis_tready is high only while no request is in progress. Results
// leave on the m_axis channel; m_axis_tlast marks the final result of
// a request.
// Add, remove and search rotate the whole slot chain once past a single
// compare point at its head, one slot per cycle while no search match is
// stalled by the output; a finish step and a result step follow the scan.
// An add into a full store and an unused command skip the scan and go
// straight to the result step.
// A search that finds several values holds each back until the scan passes
// the next match, then sends it through the output register.
// When the receiver stalls, the output register holds its result and the
// scan pauses if a further match needs it; no result is lost.
// Reset empties the store (pair and key counts to zero) and drops any
// request in progress; slot contents are not cleared.
module multimap_pair_store (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // cmd [1:0], key [33:2], value [65:34], zero fill [71:66]
  input  logic [mmps_pkg::InTdataW-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // status [1:0], found_value [33:2], pair_total [40:34], distinct_keys [47:41]
  output logic [mmps_pkg::OutTdataW-1:0]    m_axis_tdata,
  output logic                              m_axis_tlast
);
  import mmps_pkg::*;

  localparam logic [IdxW-1:0] LastStep = IdxW'(PairCapacity - 1);
  localparam logic [CntW-1:0] FullCnt  = CntW'(PairCapacity);

  state_e state_q, state_d;

  logic [IdxW-1:0]  step_q, step_d;
  logic [1:0]       cmd_q, cmd_d;
  logic [DataW-1:0] key_q, key_d;
  logic [DataW-1:0] val_q, val_d;
  logic [CntW-1:0]  pair_cnt_q, pair_cnt_d;
  logic [CntW-1:0]  key_cnt_q, key_cnt_d;
  logic             seen_q, seen_d;
  logic             hit_q, hit_d;
  logic [IdxW-1:0]  hit_idx_q, hit_idx_d;
  logic             other_q, other_d;
  logic             skip_q, skip_d;
  logic             pend_valid_q, pend_valid_d;
  logic [DataW-1:0] pend_val_q, pend_val_d;

  logic             out_valid_q, out_valid_d;
  logic [1:0]       out_status_q, out_status_d;
  logic [DataW-1:0] out_value_q, out_value_d;
  logic             out_last_q, out_last_d;
  logic [CntW-1:0]  out_pairs_q, out_pairs_d;
  logic [CntW-1:0]  out_keys_q, out_keys_d;

  logic [1:0]       in_cmd;
  logic [DataW-1:0] in_key;
  logic [DataW-1:0] in_val;

  cell_ctrl_t       ctrl;
  logic [DataW-1:0] tail_key, tail_val;
  logic [DataW-1:0] cell_key [PairCapacity];
  logic [DataW-1:0] cell_val [PairCapacity];
  logic [DataW-1:0] head_key, head_val;
  logic             in_range, kmatch, vmatch, out_free, stall;

  // unpack request
  assign in_cmd = s_axis_tdata[1:0];
  assign in_key = s_axis_tdata[33:2];
  assign in_val = s_axis_tdata[65:34];

  // slot chain: each cell loads from the one behind it, the tail from the head
  for (genvar i = 0; i < PairCapacity; i++) begin : g_cell
    logic [DataW-1:0] nxt_key, nxt_val;
    if (i == PairCapacity - 1) begin : g_tail
      assign nxt_key = tail_key;
      assign nxt_val = tail_val;
    end else begin : g_body
      assign nxt_key = cell_key[i+1];
      assign nxt_val = cell_val[i+1];
    end
    mmps_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (IdxW'(i)),
      .key_i   (nxt_key),
      .value_i (nxt_val),
      .key_o   (cell_key[i]),
      .value_o (cell_val[i])
    );
  end

  // compare point at the head of the chain
  assign head_key = cell_key[0];
  assign head_val = cell_val[0];
  assign in_range = CntW'(step_q) < pair_cnt_q;
  assign kmatch   = head_key == key_q;
  assign vmatch   = head_val == val_q;
  assign out_free = !out_valid_q || m_axis_tready;
  assign stall    = (cmd_q == CmdSearch) && in_range && kmatch && pend_valid_q && !out_free;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_cnt_q   <= '0;
      key_cnt_q    <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      step_q       <= '0;
      seen_q       <= 1'b0;
      hit_q        <= 1'b0;
      other_q      <= 1'b0;
      skip_q       <= 1'b0;
    end else begin
      pair_cnt_q   <= pair_cnt_d;
      key_cnt_q    <= key_cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      step_q       <= step_d;
      seen_q       <= seen_d;
      hit_q        <= hit_d;
      other_q      <= other_d;
      skip_q       <= skip_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    val_q        <= val_d;
    hit_idx_q    <= hit_idx_d;
    pend_val_q   <= pend_val_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_last_q   <= out_last_d;
    out_pairs_q  <= out_pairs_d;
    out_keys_q   <= out_keys_d;
  end

  // sequencer: next state, chain control and result generation
  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    val_d        = val_q;
    pair_cnt_d   = pair_cnt_q;
    key_cnt_d    = key_cnt_q;
    seen_d       = seen_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    other_d      = other_q;
    skip_d       = skip_q;
    pend_valid_d = pend_valid_q;
    pend_val_d   = pend_val_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_last_d   = out_last_q;
    out_pairs_d  = out_pairs_q;
    out_keys_d   = out_keys_q;
    ctrl         = '0;
    tail_key     = head_key;
    tail_val     = head_val;

    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          cmd_d        = in_cmd;
          key_d        = in_key;
          val_d        = in_val;
          step_d       = '0;
          seen_d       = 1'b0;
          hit_d        = 1'b0;
          other_d      = 1'b0;
          pend_valid_d = 1'b0;
          if ((in_cmd inside {CmdRemove, CmdSearch}) ||
              ((in_cmd == CmdAdd) && (pair_cnt_q < FullCnt))) begin
            skip_d  = 1'b0;
            state_d = StScan;
          end else begin
            skip_d  = 1'b1;
            state_d = StResult;
          end
        end
      end

      StScan: begin
        if (!stall) begin
          ctrl.shift = 1'b1;
          step_d     = step_q + 1'b1;
          case (cmd_q)
            CmdAdd: begin
              // new pair drops into the first free slot as it passes the tail
              if (CntW'(step_q) == pair_cnt_q) begin
                tail_key = key_q;
                tail_val = val_q;
              end
              if (in_range && kmatch) begin
                seen_d = 1'b1;
              end
            end
            CmdRemove: begin
              if (in_range && kmatch && vmatch && !hit_q) begin
                hit_d     = 1'b1;
                hit_idx_d = step_q;
              end else if (in_range && kmatch) begin
                other_d = 1'b1;
              end
            end
            CmdSearch: begin
              // hold one match back so the final one can carry last
              if (in_range && kmatch) begin
                if (pend_valid_q) begin
                  out_valid_d  = 1'b1;
                  out_status_d = StatOk;
                  out_value_d  = pend_val_q;
                  out_last_d   = 1'b0;
                  out_pairs_d  = pair_cnt_q;
                  out_keys_d   = key_cnt_q;
                end
                pend_valid_d = 1'b1;
                pend_val_d   = head_val;
              end
            end
            default: begin
            end
          endcase
          if (step_q == LastStep) begin
            state_d = StFinish;
          end
        end
      end

      StFinish: begin
        if (cmd_q == CmdAdd) begin
          pair_cnt_d = pair_cnt_q + 1'b1;
          if (!seen_q) begin
            key_cnt_d = key_cnt_q + 1'b1;
          end
        end else if ((cmd_q == CmdRemove) && hit_q) begin
          // close the gap left by the removed pair
          ctrl.compact  = 1'b1;
          ctrl.drop_idx = hit_idx_q;
          pair_cnt_d    = pair_cnt_q - 1'b1;
          if (!other_q && (key_cnt_q != '0)) begin
            key_cnt_d = key_cnt_q - 1'b1;
          end
        end
        state_d = StResult;
      end

      StResult: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_last_d   = 1'b1;
          out_value_d  = '0;
          out_pairs_d  = pair_cnt_q;
          out_keys_d   = key_cnt_q;
          out_status_d = StatNotFound;
          case (cmd_q)
            CmdAdd: begin
              out_status_d = skip_q ? StatFull : StatOk;
            end
            CmdRemove: begin
              out_status_d = hit_q ? StatOk : StatNotFound;
            end
            CmdSearch: begin
              if (pend_valid_q) begin
                out_status_d = StatOk;
                out_value_d  = pend_val_q;
              end
            end
            default: begin
              out_status_d = StatNotFound;
            end
          endcase
          pend_valid_d = 1'b0;
          state_d      = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // ports
  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_keys_q, out_pairs_q, out_value_q, out_status_q};
  assign m_axis_tlast  = out_last_q;

  // checks
  a_pair_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_cnt_q <= FullCnt)
    else $error("pair count above capacity");

  a_key_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_cnt_q <= pair_cnt_q)
    else $error("more distinct keys than pairs");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !pend_valid_q)
    else $error("search match left pending while idle");

  a_hit_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != StIdle) && hit_q) |-> (cmd_q == CmdRemove))
    else $error("removal hit recorded for another command");

  a_compact_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFinish) |=> (state_q == StResult))
    else $error("finish step not followed by result");

endmodule
